// ===== rtl/core/rgbab_pkg.sv =====
// Shared types and constants of the RGBA box-blur bloom engine.
package rgbab_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam int LANES     = 4;
	localparam int CH_W      = 8;
	localparam int SUM_W     = 13;
	localparam int CNT_W     = 5;
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [2:0] PASS_LIMIT = 3'd4;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;
	localparam logic [1:0] REG_PASSES = 2'd3;

	localparam logic [8:0] RST_WIDTH  = 9'd256;
	localparam logic [8:0] RST_HEIGHT = 9'd256;
	localparam logic [3:0] RST_RADIUS = 4'd2;
	localparam logic [2:0] RST_PASSES = 3'd2;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	typedef logic [LANES-1:0][SUM_W-1:0] lane_sum_t;
	typedef logic [LANES-1:0][CH_W-1:0]  lane_quo_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_PIX,
		ST_RD,
		ST_ACC,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_WB,
		ST_LOOK_RD,
		ST_LOOK_OUT
	} state_t;

endpackage

// ===== rtl/core/rgbab_ram.sv =====
// Single-port-write, single-port-read frame memory with registered read data.
module rgbab_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [DW-1:0] wd,
	input  logic [AW-1:0] ra,
	output logic [DW-1:0] rd
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd <= mem[ra];
	end

endmodule

// ===== rtl/core/rgbab_div.sv =====
// Four-lane restoring divider that divides channel sums by the window count.
module rgbab_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  rgbab_pkg::lane_sum_t       dividend,
	input  logic [rgbab_pkg::CNT_W-1:0] divisor,
	output logic                       ready,
	output rgbab_pkg::lane_quo_t       quotient
);
	import rgbab_pkg::*;

	logic [LANES-1:0][SUM_W-1:0] quo_q;
	logic [LANES-1:0][CNT_W-1:0] rem_q;
	logic [CNT_W-1:0]            dvs_q;
	logic [STEP_W-1:0]           step_q;
	logic                        run_q;
	logic                        ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			ready_q <= 1'b0;
			step_q  <= '0;
		end else begin
			ready_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					run_q   <= 1'b0;
					ready_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [CNT_W:0] trial;
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			for (int l = 0; l < LANES; l++) begin
				trial = {rem_q[l], quo_q[l][SUM_W-1]};
				if (trial >= {1'b0, dvs_q}) begin
					rem_q[l] <= CNT_W'(trial - {1'b0, dvs_q});
					quo_q[l] <= {quo_q[l][SUM_W-2:0], 1'b1};
				end else begin
					rem_q[l] <= trial[CNT_W-1:0];
					quo_q[l] <= {quo_q[l][SUM_W-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quotient[l] = quo_q[l][CH_W-1:0];
		end
	end

	assign ready = ready_q;

endmodule

// ===== rtl/core/rgba_box_blur_bloom.sv =====
// Top level of the RGBA box-blur bloom engine: registers, sequencer and frame memories.
//
// A pixel write (req_type 0) is taken without raising busy. A read (req_type 1) returns its
// result on pixel_out and out_index, marked by a one-cycle done strobe, after the states
// ST_LOOK_RD and ST_LOOK_OUT when the blurred frame is current; the receiver cannot stall
// and must take the result in that cycle. A read outside the frame answers with zero
// on the cycle after the transfer. The first read after any in-range pixel write or register
// write first rebuilds the blurred frame: it copies the sharp frame, then, for each pass,
// runs a horizontal and then a vertical box pass; each output pixel takes one memory read per
// window pixel inside the image and a division by the thirteen-step divider. busy stays
// high while a read inside the frame is in work; pixel writes do not raise it.
module rgba_box_blur_bloom #(
	parameter int MAX_WIDTH  = rgbab_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rgbab_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [15:0] pixel_index,
	input  logic [31:0] pixel_in,
	output logic        done,
	output logic [31:0] pixel_out,
	output logic [15:0] out_index
);
	import rgbab_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = AW + 1;
	localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int CW    = $clog2(MAXD + 1);
	localparam int PW    = 2 * CW;

	state_t st_q, st_nxt;

	logic [8:0] width_q, height_q;
	logic [3:0] radius_q;
	logic [2:0] passes_q;
	logic       valid_q;

	logic [CW-1:0] eff_w, eff_h;
	logic [2:0]    eff_p;
	logic [TW-1:0] total;
	logic          in_range, accept, cfg_we;

	logic [15:0]   idx_q;
	logic [AW-1:0] addr_q, cnt_q;
	logic [CW-1:0] x_q, y_q, k_q, hi_q;
	logic          dir_q;
	logic [2:0]    pass_q;
	logic [CNT_W-1:0] n_q;
	lane_sum_t     sum_q;

	logic          done_q;
	logic [31:0]   pix_out_q;
	logic [15:0]   out_idx_q;

	logic          sharp_we, work_we, temp_we;
	logic [AW-1:0] work_wa, work_ra, sharp_ra, mem_addr;
	logic [31:0]   work_wd, sharp_rd, work_rd, temp_rd, src_rd, blur_pix;
	logic [CW-1:0] mul_a, add_b;
	logic [PW-1:0] prod;
	logic          div_go, div_ready;
	lane_quo_t     div_quo;

	logic [CW:0]   pos, len, pos_r, lo_w, hi_w;
	logic          copy_last, frame_end, last_pass;

	function automatic logic [CW-1:0] clamp_dim(input logic [8:0] v, input int lim);
		logic [31:0] e;
		e = 32'(v);
		if (e == 32'd0) begin
			e = 32'd1;
		end else if (e > 32'(lim)) begin
			e = 32'(lim);
		end
		return CW'(e);
	endfunction

	function automatic logic [31:0] bloom(input logic [31:0] s, input logic [31:0] b);
		logic [31:0] res;
		logic [8:0]  c;
		logic [15:0] p;
		logic [16:0] q;
		res = '0;
		for (int i = 0; i < 3; i++) begin
			c = {1'b0, s[8*i +: 8]} + {1'b0, b[8*i +: 8]};
			res[8*i +: 8] = c[8:1];
		end
		p = 16'(s[31:24]) * 16'(b[31:24]);
		q = (17'(p) + 17'd1 + 17'(p[15:8])) >> 8;
		res[31:24] = 8'(s[31:24]) + b[31:24] - q[7:0];
		return res;
	endfunction

	assign eff_w    = clamp_dim(width_q, MAX_WIDTH);
	assign eff_h    = clamp_dim(height_q, MAX_HEIGHT);
	assign eff_p    = (passes_q > PASS_LIMIT) ? PASS_LIMIT : passes_q;
	assign total    = TW'(PW'(eff_w) * PW'(eff_h));
	assign in_range = 32'(pixel_index) < 32'(total);
	assign busy     = (st_q != ST_IDLE);
	assign accept   = start && !busy;
	assign cfg_we   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_RADIUS: prdata = 32'(radius_q);
			REG_PASSES: prdata = 32'(passes_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			radius_q <= RST_RADIUS;
			passes_q <= RST_PASSES;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[8:0];
				REG_HEIGHT: height_q <= pwdata[8:0];
				REG_RADIUS: radius_q <= pwdata[3:0];
				REG_PASSES: passes_q <= pwdata[2:0];
				default:    ;
			endcase
		end
	end

	// Shared address multiplier: element reads in the blur loops and pixel writeback.
	assign mul_a    = (st_q == ST_RD && dir_q) ? k_q : y_q;
	assign add_b    = (st_q == ST_RD && !dir_q) ? k_q : x_q;
	assign prod     = PW'(mul_a) * PW'(eff_w);
	assign mem_addr = AW'(prod + PW'(add_b));

	assign pos   = dir_q ? {1'b0, y_q} : {1'b0, x_q};
	assign len   = dir_q ? {1'b0, eff_h} : {1'b0, eff_w};
	assign pos_r = pos + (CW+1)'(radius_q);
	assign lo_w  = (pos >= (CW+1)'(radius_q)) ? pos - (CW+1)'(radius_q) : '0;
	assign hi_w  = (pos_r < len) ? pos_r : len - 1'b1;

	assign copy_last = ({1'b0, cnt_q} == total - 1'b1);
	assign frame_end = (x_q == eff_w - 1'b1) && (y_q == eff_h - 1'b1);
	assign last_pass = (pass_q + 1'b1 == eff_p);
	assign src_rd    = dir_q ? temp_rd : work_rd;
	assign blur_pix  = {div_quo[3], div_quo[2], div_quo[1], div_quo[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	always_comb begin
		st_nxt   = st_q;
		sharp_we = 1'b0;
		work_we  = 1'b0;
		temp_we  = 1'b0;
		div_go   = 1'b0;
		work_wa  = mem_addr;
		work_wd  = blur_pix;
		work_ra  = mem_addr;
		sharp_ra = addr_q;
		case (st_q)
			ST_IDLE: begin
				if (accept && in_range) begin
					if (req_type == REQ_WRITE) begin
						sharp_we = 1'b1;
					end else begin
						st_nxt = valid_q ? ST_LOOK_RD : ST_COPY_RD;
					end
				end
			end
			ST_COPY_RD: begin
				sharp_ra = cnt_q;
				st_nxt   = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				work_we = 1'b1;
				work_wa = cnt_q;
				work_wd = sharp_rd;
				if (copy_last) begin
					st_nxt = (eff_p == 3'd0) ? ST_LOOK_RD : ST_PIX;
				end else begin
					st_nxt = ST_COPY_RD;
				end
			end
			ST_PIX: st_nxt = ST_RD;
			ST_RD:  st_nxt = ST_ACC;
			ST_ACC: st_nxt = (k_q == hi_q) ? ST_DIV_GO : ST_RD;
			ST_DIV_GO: begin
				div_go = 1'b1;
				st_nxt = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_ready) begin
					st_nxt = ST_WB;
				end
			end
			ST_WB: begin
				temp_we = !dir_q;
				work_we = dir_q;
				st_nxt  = (frame_end && dir_q && last_pass) ? ST_LOOK_RD : ST_PIX;
			end
			ST_LOOK_RD: begin
				work_ra = addr_q;
				st_nxt  = ST_LOOK_OUT;
			end
			ST_LOOK_OUT: st_nxt = ST_IDLE;
			default: st_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			k_q     <= '0;
			hi_q    <= '0;
			dir_q   <= 1'b0;
			pass_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we || sharp_we) begin
				valid_q <= 1'b0;
			end else if ((st_q == ST_COPY_WR || st_q == ST_WB) && st_nxt == ST_LOOK_RD) begin
				valid_q <= 1'b1;
			end
			case (st_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					x_q    <= '0;
					y_q    <= '0;
					dir_q  <= 1'b0;
					pass_q <= '0;
					if (accept && req_type == REQ_READ && !in_range) begin
						done_q <= 1'b1;
					end
				end
				ST_COPY_WR: cnt_q <= cnt_q + 1'b1;
				ST_PIX: begin
					k_q  <= lo_w[CW-1:0];
					hi_q <= hi_w[CW-1:0];
				end
				ST_ACC: k_q <= k_q + 1'b1;
				ST_WB: begin
					if (x_q == eff_w - 1'b1) begin
						x_q <= '0;
						if (y_q == eff_h - 1'b1) begin
							y_q <= '0;
							if (dir_q) begin
								pass_q <= pass_q + 1'b1;
							end
							dir_q <= !dir_q;
						end else begin
							y_q <= y_q + 1'b1;
						end
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
				ST_LOOK_OUT: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] idx_ext;
		idx_ext = 32'(pixel_index);
		if (accept) begin
			idx_q  <= pixel_index;
			addr_q <= idx_ext[AW-1:0];
			if (req_type == REQ_READ && !in_range) begin
				pix_out_q <= '0;
				out_idx_q <= pixel_index;
			end
		end
		if (st_q == ST_PIX) begin
			n_q   <= CNT_W'(hi_w - lo_w + 1'b1);
			sum_q <= '0;
		end
		if (st_q == ST_ACC) begin
			for (int l = 0; l < LANES; l++) begin
				sum_q[l] <= sum_q[l] + SUM_W'(src_rd[8*l +: 8]);
			end
		end
		if (st_q == ST_LOOK_OUT) begin
			pix_out_q <= bloom(sharp_rd, work_rd);
			out_idx_q <= idx_q;
		end
	end

	assign done      = done_q;
	assign pixel_out = pix_out_q;
	assign out_index = out_idx_q;

	rgbab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (sum_q),
		.divisor  (n_q),
		.ready    (div_ready),
		.quotient (div_quo)
	);

	rgbab_ram #(.DEPTH(DEPTH), .AW(AW), .DW(32)) u_sharp (
		.clk (clk),
		.we  (sharp_we),
		.wa  (AW'(pixel_index)),
		.wd  (pixel_in),
		.ra  (sharp_ra),
		.rd  (sharp_rd)
	);

	rgbab_ram #(.DEPTH(DEPTH), .AW(AW), .DW(32)) u_work (
		.clk (clk),
		.we  (work_we),
		.wa  (work_wa),
		.wd  (work_wd),
		.ra  (work_ra),
		.rd  (work_rd)
	);

	rgbab_ram #(.DEPTH(DEPTH), .AW(AW), .DW(32)) u_temp (
		.clk (clk),
		.we  (temp_we),
		.wa  (mem_addr),
		.wd  (blur_pix),
		.ra  (mem_addr),
		.rd  (temp_rd)
	);

endmodule

// ===== sim/tb.sv =====
// Testbench of rgba_box_blur_bloom: random pixel loads and bloom reads checked against a predictor.
`timescale 1ns / 100ps

module tb;
	import rgbab_pkg::*;

	localparam int FRAME_PIXELS = 65536;
	localparam int CYCLE_LIMIT  = 4000000;

	typedef struct {
		logic        kind;
		logic [15:0] index;
		logic [31:0] data;
	} request_t;

	typedef struct {
		logic [31:0] pixel;
		logic [15:0] index;
	} bloom_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic        req_type;
	logic [15:0] pixel_index;
	logic [31:0] pixel_in;
	logic        done;
	logic [31:0] pixel_out;
	logic [15:0] out_index;

	rgba_box_blur_bloom dut (.*);

	request_t pending_requests[$];
	bloom_t   expected_blooms[$];

	bit [31:0] sharp_px[FRAME_PIXELS];
	bit [31:0] blurred_px[FRAME_PIXELS];
	bit [31:0] scratch_px[FRAME_PIXELS];
	bit        blur_fresh;
	bit [8:0]  cfg_width;
	bit [8:0]  cfg_height;
	bit [3:0]  cfg_radius;
	bit [2:0]  cfg_passes;

	int  issued_cnt;
	int  accepted_cnt;
	int  gap_left;
	int  burst_left;
	int  cycle_cnt;
	bit  failed;

	always #10 clk = ~clk;

	function automatic int frame_w();
		if (cfg_width == 0) return 1;
		return cfg_width > 256 ? 256 : int'(cfg_width);
	endfunction

	function automatic int frame_h();
		if (cfg_height == 0) return 1;
		return cfg_height > 256 ? 256 : int'(cfg_height);
	endfunction

	function automatic void rebuild_blur();
		int w, h, r, np, lo, hi, n;
		int sum[4];
		bit [31:0] p, v;
		w = frame_w();
		h = frame_h();
		r = cfg_radius;
		np = cfg_passes > PASS_LIMIT ? int'(PASS_LIMIT) : int'(cfg_passes);
		for (int i = 0; i < w * h; i++) blurred_px[i] = sharp_px[i];
		for (int ps = 0; ps < np; ps++) begin
			for (int y = 0; y < h; y++)
				for (int x = 0; x < w; x++) begin
					lo = x >= r ? x - r : 0;
					hi = x + r < w ? x + r : w - 1;
					n = hi - lo + 1;
					sum = '{0, 0, 0, 0};
					for (int k = lo; k <= hi; k++) begin
						p = blurred_px[y * w + k];
						for (int c = 0; c < 4; c++) sum[c] += p[8*c +: 8];
					end
					for (int c = 0; c < 4; c++) v[8*c +: 8] = 8'(sum[c] / n);
					scratch_px[y * w + x] = v;
				end
			for (int y = 0; y < h; y++)
				for (int x = 0; x < w; x++) begin
					lo = y >= r ? y - r : 0;
					hi = y + r < h ? y + r : h - 1;
					n = hi - lo + 1;
					sum = '{0, 0, 0, 0};
					for (int k = lo; k <= hi; k++) begin
						p = scratch_px[k * w + x];
						for (int c = 0; c < 4; c++) sum[c] += p[8*c +: 8];
					end
					for (int c = 0; c < 4; c++) v[8*c +: 8] = 8'(sum[c] / n);
					blurred_px[y * w + x] = v;
				end
		end
		blur_fresh = 1;
	endfunction

	function automatic bit [31:0] bloom_of(bit [31:0] s, bit [31:0] b);
		bit [31:0] res;
		int as, ab;
		for (int c = 0; c < 3; c++)
			res[8*c +: 8] = 8'((int'(s[8*c +: 8]) + int'(b[8*c +: 8])) / 2);
		as = s[31:24];
		ab = b[31:24];
		res[31:24] = 8'(as + ab - (as * ab) / 255);
		return res;
	endfunction

	function automatic void predict_request(request_t rq);
		int total;
		bloom_t e;
		total = frame_w() * frame_h();
		if (rq.kind == REQ_WRITE) begin
			if (rq.index < total) begin
				sharp_px[rq.index] = rq.data;
				blur_fresh = 0;
			end
			return;
		end
		e.index = rq.index;
		if (rq.index >= total) e.pixel = 0;
		else begin
			if (!blur_fresh) rebuild_blur();
			e.pixel = bloom_of(sharp_px[rq.index], blurred_px[rq.index]);
		end
		expected_blooms.push_back(e);
	endfunction

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		bloom_t e;
		if (arst_n && start && !busy) begin
			predict_request('{req_type, pixel_index, pixel_in});
			accepted_cnt++;
		end
		if (arst_n && done) begin
			if (expected_blooms.size() == 0) begin
				$error("unexpected result: pixel_out %h out_index %h", pixel_out, out_index);
				failed = 1;
			end else begin
				e = expected_blooms.pop_front();
				if (pixel_out !== e.pixel) begin
					$error("pixel_out expected %h actual %h", e.pixel, pixel_out);
					failed = 1;
				end
				if (out_index !== e.index) begin
					$error("out_index expected %h actual %h", e.index, out_index);
					failed = 1;
				end
			end
		end
	end

	always @(negedge clk) begin
		request_t rq;
		if (arst_n && !(start && issued_cnt != accepted_cnt)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 0;
			end else if (pending_requests.size() > 0) begin
				rq = pending_requests.pop_front();
				req_type <= rq.kind;
				pixel_index <= rq.index;
				pixel_in <= rq.data;
				start <= 1;
				issued_cnt++;
				if (burst_left > 0) begin
					burst_left--;
					gap_left = 0;
				end else begin
					if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 60);
					gap_left = $urandom_range(0, 14);
				end
			end else start <= 0;
		end
	end

	task automatic reg_write(logic [1:0] reg_id, logic [31:0] value);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {reg_id, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (reg_id)
			REG_WIDTH:  cfg_width = value[8:0];
			REG_HEIGHT: cfg_height = value[8:0];
			REG_RADIUS: cfg_radius = value[3:0];
			REG_PASSES: cfg_passes = value[2:0];
			default:    ;
		endcase
		blur_fresh = 0;
	endtask

	task automatic wait_idle();
		wait (pending_requests.size() == 0 && issued_cnt == accepted_cnt &&
			expected_blooms.size() == 0);
		repeat (12) @(posedge clk);
		wait (!busy);
	endtask

	function automatic logic [31:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic run_frame(int w, int h, int r, int p, int mixed, int rewrite_pct);
		int total, pick;
		logic [31:0] garbage;
		garbage = $urandom;
		wait_idle();
		reg_write(REG_WIDTH, {garbage[31:9], 9'(w)});
		reg_write(REG_HEIGHT, {garbage[31:9], 9'(h)});
		reg_write(REG_RADIUS, {garbage[31:4], 4'(r)});
		reg_write(REG_PASSES, {garbage[31:3], 3'(p)});
		total = frame_w() * frame_h();
		for (int i = 0; i < total; i++)
			pending_requests.push_back('{REQ_WRITE, 16'(i), rand_pixel()});
		for (int i = 0; i < mixed; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < rewrite_pct)
				pending_requests.push_back('{REQ_WRITE, 16'($urandom_range(0, total - 1)),
					rand_pixel()});
			else if (pick < rewrite_pct + 5)
				pending_requests.push_back('{REQ_WRITE, 16'($urandom_range(total, 65535)),
					rand_pixel()});
			else if (pick < rewrite_pct + 12)
				pending_requests.push_back('{REQ_READ, 16'($urandom_range(total, 65535)),
					32'($urandom)});
			else
				pending_requests.push_back('{REQ_READ, 16'($urandom_range(0, total - 1)),
					32'($urandom)});
		end
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		start = 0;
		req_type = 0;
		pixel_index = 0;
		pixel_in = 0;
		cfg_width = RST_WIDTH;
		cfg_height = RST_HEIGHT;
		cfg_radius = RST_RADIUS;
		cfg_passes = RST_PASSES;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		run_frame(4, 3, 1, 1, 0, 0);
		pending_requests.push_back('{REQ_READ, 16'd0, 32'h0});
		pending_requests.push_back('{REQ_READ, 16'd11, 32'hFFFF_FFFF});
		pending_requests.push_back('{REQ_READ, 16'd12, 32'h0});
		pending_requests.push_back('{REQ_READ, 16'hFFFF, 32'h0});
		pending_requests.push_back('{REQ_WRITE, 16'hFFFF, 32'hFFFF_FFFF});
		pending_requests.push_back('{REQ_READ, 16'd5, 32'h0});
		pending_requests.push_back('{REQ_WRITE, 16'd5, 32'hFFFF_FFFF});
		pending_requests.push_back('{REQ_READ, 16'd5, 32'h0});
		run_frame(0, 0, 0, 0, 12, 20);
		run_frame(511, 1, 15, 7, 20, 0);
		run_frame(1, 300, 15, 4, 20, 0);
		run_frame(8, 2, 0, 4, 40, 8);
		for (int ph = 0; ph < 12; ph++)
			run_frame($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(0, 15),
				$urandom_range(0, 7), 100, 8);
		wait_idle();
		repeat (20) @(posedge clk);
		if (expected_blooms.size() != 0) begin
			$error("%0d results never arrived", expected_blooms.size());
			failed = 1;
		end
		if (!failed) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
